// ===== hw/rtl/b64d_pkg.sv =====
// shared types and constants of the base64 decoder
package b64d_pkg;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;
    localparam logic [7:0] INVALID_SEXTET = 8'h80;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  top_idx;
        logic        last;
        logic [1:0]  status;
    } t_cmd;

endpackage

// ===== hw/rtl/b64d_if.sv =====
// handshake channels of the base64 decoder
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

// ===== hw/rtl/b64d_front.sv =====
// front end: character mapping, group assembly and error detection
module b64d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output b64d_pkg::t_cmd o_cmd
);
    import b64d_pkg::*;

    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        v = INVALID_SEXTET;
        if (c inside {[8'h41:8'h5A]}) v = c - 8'h41;
        else if (c inside {[8'h61:8'h7A]}) v = c - 8'h61 + 8'd26;
        else if (c inside {[8'h30:8'h39]}) v = c - 8'h30 + 8'd52;
        else if (c == 8'h2B) v = 8'd62;
        else if (c == 8'h2F) v = 8'd63;
        else if (c == PAD_CHAR) v = 8'd0;
        return v;
    endfunction

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_pos, n_pos;
    logic        r_tpad, n_tpad;
    logic        r_drop, n_drop;

    logic        accept;
    logic [7:0]  v;
    logic [23:0] word;
    logic        send2, send3;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign v       = char_value(i_char);
    assign word    = {r_buf, v[5:0]};
    assign send2   = !r_tpad;
    assign send3   = (i_char != PAD_CHAR);

    always_comb begin
        n_buf  = r_buf;
        n_pos  = r_pos;
        n_tpad = r_tpad;
        n_drop = r_drop;
        o_push = 1'b0;
        o_cmd  = '{bytes: 24'd0, top_idx: 2'd0, last: 1'b1, status: ST_DATA};
        if (accept) begin
            if (r_drop) begin
                if (i_last) n_drop = 1'b0;
            end else if (v[7]) begin
                n_buf  = '0;
                n_pos  = '0;
                n_tpad = 1'b0;
                n_drop = !i_last;
                o_push = 1'b1;
                o_cmd.status = ST_BAD_CHAR;
            end else if (r_pos != 2'd3) begin
                if (r_pos == 2'd2) n_tpad = (i_char == PAD_CHAR);
                n_buf = {r_buf[11:0], v[5:0]};
                n_pos = r_pos + 2'd1;
                if (i_last) begin
                    n_buf  = '0;
                    n_pos  = '0;
                    n_tpad = 1'b0;
                    o_push = 1'b1;
                    o_cmd.status = ST_BAD_LEN;
                end
            end else begin
                n_buf  = '0;
                n_pos  = '0;
                n_tpad = 1'b0;
                o_push = 1'b1;
                o_cmd.last    = i_last;
                o_cmd.top_idx = {send2 & send3, send2 ^ send3};
                o_cmd.bytes[23:16] = word[23:16];
                if (send2) begin
                    o_cmd.bytes[15:8] = word[15:8];
                    o_cmd.bytes[7:0]  = word[7:0];
                end else begin
                    o_cmd.bytes[15:8] = word[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_pos  <= '0;
            r_tpad <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_pos  <= n_pos;
            r_tpad <= n_tpad;
            r_drop <= n_drop;
        end
    end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// command queue between front and back end
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b64d_pkg::t_cmd o_cmd
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        if (do_pop) n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// back end: expands queued commands into output words
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  b64d_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic [1:0]     o_status
);
    import b64d_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last;
    logic [1:0] r_status;
    logic [1:0] r_idx;
    logic       load, final_word;

    assign load       = i_valid && (!r_valid || i_ready);
    assign final_word = (r_idx == i_cmd.top_idx);
    assign o_pop      = load && final_word;

    always_comb begin
        case (r_idx)
            2'd0:    n_byte = i_cmd.bytes[23:16];
            2'd1:    n_byte = i_cmd.bytes[15:8];
            default: n_byte = i_cmd.bytes[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_word ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= n_byte;
            r_last   <= i_cmd.last && final_word;
            r_status <= i_cmd.status;
        end
    end

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

// ===== hw/rtl/base64_decoder.sv =====
// top level of the streaming base64 decoder
// Accepts one character per cycle while the command queue has room and
// delivers one result word per cycle from a registered output stage while
// the consumer is ready. Each group of four characters, each error and
// each length fault becomes one queue entry of up to three words; the
// back end drains an entry one word at a time, so the sustained rate is
// three words per four characters and the queue of QUEUE_DEPTH entries
// absorbs bursts. A completing character goes to the queue and its first
// word to the output register. Error words carry the last mark; bytes of
// that string already delivered must be discarded by the consumer.
module base64_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);
    import b64d_pkg::*;

    logic full, push, pop, q_valid;
    t_cmd push_cmd, q_cmd;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_char  (i_in.in_char),
        .i_last  (i_in.in_last),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_byte   (o_out.out_byte),
        .o_last   (o_out.out_last),
        .o_status (o_out.status)
    );

endmodule
